// File: rtl/jost_pkg.sv
`default_nettype none

package jost_pkg;

  // sizing
  localparam int MAX_MEMBERS   = 16;
  localparam int MAX_TOKEN_LEN = 1024;
  localparam int MCW           = $clog2(MAX_MEMBERS + 1);
  localparam int TCW           = 10;
  localparam int IDXW          = 4;
  localparam int TOK_LIM_FULL  = MAX_TOKEN_LEN - 1;
  localparam int TOK_LIM       = (TOK_LIM_FULL > 1023) ? 1023 : TOK_LIM_FULL;

  // characters of the grammar
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    ST_BEGIN_OBJECT = 4'd1,
    ST_BEGIN_KEY    = 4'd2,
    ST_KEY          = 4'd3,
    ST_END_KEY      = 4'd4,
    ST_BEGIN_VALUE  = 4'd5,
    ST_STRING       = 4'd6,
    ST_INT          = 4'd7,
    ST_END_VALUE    = 4'd8,
    ST_ESC          = 4'd9,
    ST_ESC_U1       = 4'd10,
    ST_ESC_U2       = 4'd11,
    ST_ESC_U3       = 4'd12,
    ST_ESC_U4       = 4'd13,
    ST_END_OBJECT   = 4'd14,
    ST_ERROR        = 4'd15
  } pstate_t;

  typedef enum logic [2:0] {
    ROLE_STRUCT = 3'd0,
    ROLE_KEY    = 3'd1,
    ROLE_STRVAL = 3'd2,
    ROLE_DIGIT  = 3'd3,
    ROLE_ERROR  = 3'd4
  } role_t;

  typedef enum logic [1:0] {
    STAT_BUSY   = 2'd0,
    STAT_ACCEPT = 2'd1,
    STAT_ERROR  = 2'd2
  } status_t;

  // tokenizer state carried from byte to byte
  typedef struct packed {
    pstate_t          st;
    logic [MCW-1:0]   mcount;
    logic [TCW-1:0]   tcount;
  } tok_state_t;

  // one result word
  typedef struct packed {
    role_t             role;
    logic [IDXW-1:0]   idx;
    logic              newm;
    logic [TCW-1:0]    pos;
    status_t           status;
  } tok_res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_esc_lit(input logic [7:0] c);
    return (c == CH_BSLASH) || (c == CH_QUOTE) || (c == CH_SLASH) || (c == CH_B) ||
           (c == CH_T) || (c == CH_N) || (c == CH_F) || (c == CH_R);
  endfunction

  // state reached by the byte that follows a value
  function automatic pstate_t after_value(input logic [7:0] c);
    if (is_ws(c)) return ST_END_VALUE;
    if (c == CH_COMMA) return ST_BEGIN_KEY;
    if (c == CH_RBRACE) return ST_END_OBJECT;
    return ST_ERROR;
  endfunction

endpackage

`default_nettype wire

// File: rtl/json_object_subset_tokenizer_unit.sv
// Byte-serial tokenizer for a flat object of lowercase keys with string or
// unsigned integer values.
// Input channel: one document byte per word on in_tdata, in_tlast marks the
// final byte of the document. Output channel: one result word per input word,
// in order; out_tuser carries the byte role and the new-member flag, out_tdata
// the member index, position inside the key or value, and document status.
// Each byte's result is registered, in the output register or the skid register.
// Throughput: one byte per cycle while in_tready is high; the tokenizer state
// update is a single combinational step from the state registers, so each byte
// can be taken without waiting on the one before it.
// A two-word output stage (result register plus skid register) lets a byte be
// taken in the cycle in which the receiver first stalls; in_tready drops only
// while the skid register is full and returns once the receiver takes a word.
// Reset (rst_n low, synchronous) empties the output stage and puts the
// tokenizer into its begin-object state with no members; the same state is
// entered after every byte marked last.
// A syntax error is sticky: every later byte of the document reports the
// error role and error status until the final byte.
`default_nettype none

module json_object_subset_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] member_index, [13:4] token_position,
                                  // [15:14] doc_status
  output logic [3:0]  out_tuser   // [2:0] byte_role, [3] new_member
);
  import jost_pkg::*;

  tok_state_t state_r;
  tok_state_t state_nxt;
  tok_res_t   res_nxt;
  tok_res_t   out_r;
  tok_res_t   skid_r;
  logic       out_v_r;
  logic       skid_v_r;
  logic       acc;

  jost_step u_step (
    .cur       (state_r),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  assign in_tready = !skid_v_r;
  assign acc       = in_tvalid && in_tready;

  // tokenizer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.st     <= ST_BEGIN_OBJECT;
      state_r.mcount <= '0;
      state_r.tcount <= '0;
    end else if (acc) begin
      state_r <= state_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= acc;
      end
    end else if (acc) begin
      skid_v_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (skid_v_r) out_r <= skid_r;
      else if (acc) out_r <= res_nxt;
    end else if (acc) begin
      skid_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.status, out_r.pos, out_r.idx};
  assign out_tuser  = {out_r.newm, out_r.role};

  // skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word without output word");

  // error role always carries error status
  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.role == ROLE_ERROR) |-> out_r.status == STAT_ERROR)
    else $error("error role without error status");

  // a new key opens on a structural byte at position zero
  a_newm_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.newm) |-> (out_r.role == ROLE_STRUCT && out_r.pos == '0))
    else $error("new member flag on a non-quote result");

  // final byte returns the tokenizer to its start state
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (state_r.st == ST_BEGIN_OBJECT && state_r.mcount == '0))
    else $error("tokenizer not restarted after final byte");

endmodule

`default_nettype wire

// File: rtl/jost_step.sv
`default_nettype none

module jost_step (
  input  jost_pkg::tok_state_t cur,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output jost_pkg::tok_state_t nxt,
  output jost_pkg::tok_res_t   res
);
  import jost_pkg::*;

  pstate_t        st;
  role_t          role;
  logic           newm;
  logic [TCW-1:0] pos;
  logic [MCW-1:0] mcount;
  logic [TCW-1:0] tcount;
  logic [TCW-1:0] tick_base;
  logic           do_tick;
  logic [TCW-1:0] tick_next;
  logic [MCW-1:0] mdec;

  // saturating position counter, base is 0 when a key or a value opens
  assign tick_next = (tick_base < TCW'(TOK_LIM)) ? tick_base + 1'b1 : tick_base;

  // per-state decode of the byte
  always_comb begin
    st        = cur.st;
    role      = ROLE_STRUCT;
    newm      = 1'b0;
    mcount    = cur.mcount;
    tick_base = cur.tcount;
    do_tick   = 1'b0;
    unique case (cur.st)
      ST_BEGIN_OBJECT: begin
        if (!is_ws(data_byte)) st = (data_byte == CH_LBRACE) ? ST_BEGIN_KEY : ST_ERROR;
      end
      ST_BEGIN_KEY: begin
        if (!is_ws(data_byte)) begin
          if (data_byte == CH_QUOTE && cur.mcount < MCW'(MAX_MEMBERS)) begin
            mcount    = cur.mcount + 1'b1;
            newm      = 1'b1;
            tick_base = '0;
            st        = ST_KEY;
          end else begin
            st = ST_ERROR;
          end
        end
      end
      ST_KEY: begin
        if (data_byte == CH_QUOTE) st = ST_END_KEY;
        else if (is_lower(data_byte)) begin
          role    = ROLE_KEY;
          do_tick = 1'b1;
        end else st = ST_ERROR;
      end
      ST_END_KEY: begin
        if (!is_ws(data_byte)) st = (data_byte == CH_COLON) ? ST_BEGIN_VALUE : ST_ERROR;
      end
      ST_BEGIN_VALUE: begin
        if (!is_ws(data_byte)) begin
          if (data_byte == CH_QUOTE) begin
            tick_base = '0;
            st        = ST_STRING;
          end else if (is_digit(data_byte)) begin
            tick_base = '0;
            role      = ROLE_DIGIT;
            do_tick   = 1'b1;
            st        = ST_INT;
          end else st = ST_ERROR;
        end
      end
      ST_INT: begin
        if (is_digit(data_byte)) begin
          role    = ROLE_DIGIT;
          do_tick = 1'b1;
        end else st = after_value(data_byte);
      end
      ST_STRING: begin
        if (data_byte == CH_QUOTE) st = ST_END_VALUE;
        else begin
          role    = ROLE_STRVAL;
          do_tick = 1'b1;
          if (data_byte == CH_BSLASH) st = ST_ESC;
        end
      end
      ST_ESC: begin
        if (is_esc_lit(data_byte)) begin
          role    = ROLE_STRVAL;
          do_tick = 1'b1;
          st      = ST_STRING;
        end else if (data_byte == CH_U) begin
          role    = ROLE_STRVAL;
          do_tick = 1'b1;
          st      = ST_ESC_U1;
        end else st = ST_ERROR;
      end
      ST_ESC_U1, ST_ESC_U2, ST_ESC_U3, ST_ESC_U4: begin
        if (is_hex(data_byte)) begin
          role    = ROLE_STRVAL;
          do_tick = 1'b1;
          st      = (cur.st == ST_ESC_U4) ? ST_STRING : pstate_t'(cur.st + 4'd1);
        end else st = ST_ERROR;
      end
      ST_END_VALUE:  st = after_value(data_byte);
      ST_END_OBJECT: begin
        if (!is_ws(data_byte)) st = ST_ERROR;
      end
      default:       st = ST_ERROR;
    endcase
  end

  assign tcount = do_tick ? tick_next : tick_base;
  assign pos    = (do_tick && st != ST_ERROR) ? tick_base : '0;
  assign mdec   = mcount - 1'b1;

  // result word
  always_comb begin
    res.role   = (st == ST_ERROR) ? ROLE_ERROR : role;
    res.newm   = (st == ST_ERROR) ? 1'b0 : newm;
    res.pos    = pos;
    res.idx    = (mcount != '0) ? IDXW'(mdec) : '0;
    if (last_byte) res.status = (st == ST_END_OBJECT) ? STAT_ACCEPT : STAT_ERROR;
    else           res.status = (st == ST_ERROR) ? STAT_ERROR : STAT_BUSY;
  end

  // next state, back to start after the final byte
  always_comb begin
    if (last_byte) begin
      nxt.st     = ST_BEGIN_OBJECT;
      nxt.mcount = '0;
      nxt.tcount = '0;
    end else begin
      nxt.st     = st;
      nxt.mcount = mcount;
      nxt.tcount = tcount;
    end
  end

endmodule

`default_nettype wire

// File: verif/json_token_checker.sv
`timescale 1ns / 100ps

module json_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [3:0] member_index, [13:4] token_position,
                                  // [15:14] doc_status
  input  logic [3:0]  out_tuser,  // [2:0] byte_role, [3] new_member
  output int          fail_count,
  output int          pending
);
  import jost_pkg::*;

  // shadow copy of the tokenizer state
  pstate_t        scan_state;
  logic [MCW-1:0] members_seen;
  logic [TCW-1:0] token_len;

  // result words predicted for accepted bytes, oldest first
  tok_res_t predicted_words[$];

  function automatic logic blank(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

  function automatic logic decimal(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // where the byte right after a value leads
  function automatic pstate_t follow_value(input logic [7:0] c);
    if (blank(c)) return ST_END_VALUE;
    if (c == CH_COMMA) return ST_BEGIN_KEY;
    if (c == CH_RBRACE) return ST_END_OBJECT;
    return ST_ERROR;
  endfunction

  // position of the current byte, counter saturates
  function automatic logic [TCW-1:0] next_pos();
    logic [TCW-1:0] p;
    p = token_len;
    if (token_len < TOK_LIM) token_len = token_len + 1'b1;
    return p;
  endfunction

  // one byte through the shadow tokenizer, returns its result word
  function automatic tok_res_t tokenize_byte(input logic [7:0] c, input logic fin);
    tok_res_t       r;
    pstate_t        nx;
    logic [MCW-1:0] last_member;
    r = '0;
    r.role = ROLE_STRUCT;
    r.status = STAT_BUSY;
    nx = scan_state;
    case (scan_state)
      ST_BEGIN_OBJECT: begin
        if (!blank(c)) nx = (c == CH_LBRACE) ? ST_BEGIN_KEY : ST_ERROR;
      end
      ST_BEGIN_KEY: begin
        if (!blank(c)) begin
          if (c == CH_QUOTE && members_seen < MAX_MEMBERS) begin
            members_seen = members_seen + 1'b1;
            r.newm = 1'b1;
            token_len = '0;
            nx = ST_KEY;
          end else begin
            nx = ST_ERROR;
          end
        end
      end
      ST_KEY: begin
        if (c == CH_QUOTE) begin
          nx = ST_END_KEY;
        end else if (c >= "a" && c <= "z") begin
          r.role = ROLE_KEY;
          r.pos = next_pos();
        end else begin
          nx = ST_ERROR;
        end
      end
      ST_END_KEY: begin
        if (!blank(c)) nx = (c == CH_COLON) ? ST_BEGIN_VALUE : ST_ERROR;
      end
      ST_BEGIN_VALUE: begin
        if (!blank(c)) begin
          if (c == CH_QUOTE) begin
            token_len = '0;
            nx = ST_STRING;
          end else if (decimal(c)) begin
            token_len = '0;
            r.role = ROLE_DIGIT;
            r.pos = next_pos();
            nx = ST_INT;
          end else begin
            nx = ST_ERROR;
          end
        end
      end
      ST_INT: begin
        if (decimal(c)) begin
          r.role = ROLE_DIGIT;
          r.pos = next_pos();
        end else begin
          nx = follow_value(c);
        end
      end
      ST_STRING: begin
        if (c == CH_QUOTE) begin
          nx = ST_END_VALUE;
        end else begin
          r.role = ROLE_STRVAL;
          r.pos = next_pos();
          if (c == CH_BSLASH) nx = ST_ESC;
        end
      end
      ST_ESC: begin
        if (c == CH_BSLASH || c == CH_QUOTE || c == CH_SLASH || c == CH_B ||
            c == CH_T || c == CH_N || c == CH_F || c == CH_R) begin
          r.role = ROLE_STRVAL;
          r.pos = next_pos();
          nx = ST_STRING;
        end else if (c == CH_U) begin
          r.role = ROLE_STRVAL;
          r.pos = next_pos();
          nx = ST_ESC_U1;
        end else begin
          nx = ST_ERROR;
        end
      end
      ST_ESC_U1, ST_ESC_U2, ST_ESC_U3, ST_ESC_U4: begin
        if (decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
          r.role = ROLE_STRVAL;
          r.pos = next_pos();
          nx = (scan_state == ST_ESC_U4) ? ST_STRING : pstate_t'(scan_state + 4'd1);
        end else begin
          nx = ST_ERROR;
        end
      end
      ST_END_VALUE: begin
        nx = follow_value(c);
      end
      ST_END_OBJECT: begin
        if (!blank(c)) nx = ST_ERROR;
      end
      default: begin
        nx = ST_ERROR;
      end
    endcase

    // error role masks position and new-member flag
    if (nx == ST_ERROR) begin
      r.role = ROLE_ERROR;
      r.pos = '0;
      r.newm = 1'b0;
    end
    last_member = members_seen - 1'b1;
    r.idx = (members_seen == 0) ? '0 : last_member[IDXW-1:0];

    // final byte judges the document and restarts the tokenizer
    if (fin) begin
      r.status = (nx == ST_END_OBJECT) ? STAT_ACCEPT : STAT_ERROR;
      scan_state = ST_BEGIN_OBJECT;
      members_seen = '0;
      token_len = '0;
    end else begin
      r.status = (nx == ST_ERROR) ? STAT_ERROR : STAT_BUSY;
      scan_state = nx;
    end
    return r;
  endfunction

  task automatic log_failure(input string what, input tok_res_t want, input tok_res_t got);
    fail_count++;
    if (fail_count <= 10)
      $display({"%0t %s: expected role %0d idx %0d new %0b pos %0d status %0d,",
                " got role %0d idx %0d new %0b pos %0d status %0d"},
               $realtime, what, want.role, want.idx, want.newm, want.pos, want.status,
               got.role, got.idx, got.newm, got.pos, got.status);
  endtask

  // compare taken result words, then predict for the byte taken at this edge
  always @(posedge clk) begin
    tok_res_t want;
    tok_res_t got;
    if (!rst_n) begin
      scan_state = ST_BEGIN_OBJECT;
      members_seen = '0;
      token_len = '0;
      predicted_words.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.role = role_t'(out_tuser[2:0]);
        got.newm = out_tuser[3];
        got.idx = out_tdata[3:0];
        got.pos = out_tdata[13:4];
        got.status = status_t'(out_tdata[15:14]);
        if (predicted_words.size() == 0) begin
          log_failure("word with nothing expected", '0, got);
        end else begin
          want = predicted_words.pop_front();
          if (got.role !== want.role || got.idx !== want.idx || got.newm !== want.newm ||
              got.pos !== want.pos || got.status !== want.status)
            log_failure("word mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready)
        predicted_words.push_back(tokenize_byte(in_tdata, in_tlast));
    end
    pending = predicted_words.size();
  end

endmodule

// File: verif/json_object_subset_tokenizer_unit_test.sv
`timescale 1ns / 100ps

module json_object_subset_tokenizer_unit_test;
  import jost_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT     = 12;
  localparam int RANDOM_WORDS = 900;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int LONG_VALUE   = 1030;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [15:0] out_tdata;
  wire  [3:0]  out_tuser;

  int   fail_count;
  int   pending;
  int   words_sent = 0;
  int   quiet_cycles = 0;
  logic calm = 1'b0;

  // document under construction
  logic [7:0] doc[$];

  json_object_subset_tokenizer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  json_token_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending(pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver stalls at random outside the calm stretch
  always @(posedge clk)
    out_tready <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void put_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) doc.push_back(s[k]);
  endfunction

  // optional run of whitespace between tokens
  function automatic void put_blanks();
    int k;
    int n;
    n = ($urandom_range(99) < 30) ? $urandom_range(1, 2) : 0;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: doc.push_back(CH_TAB);
        1: doc.push_back(CH_LF);
        2: doc.push_back(CH_CR);
        default: doc.push_back(CH_SPACE);
      endcase
    end
  endfunction

  // quoted string value with plain bytes, short escapes and unicode escapes
  function automatic void put_string(input int len);
    logic [7:0] esc_lit[8];
    logic [7:0] b;
    int k;
    int j;
    int h;
    esc_lit = '{CH_BSLASH, CH_QUOTE, CH_SLASH, CH_B, CH_T, CH_N, CH_F, CH_R};
    doc.push_back(CH_QUOTE);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(9))
        0: begin
          doc.push_back(CH_BSLASH);
          doc.push_back(esc_lit[$urandom_range(7)]);
        end
        1: begin
          doc.push_back(CH_BSLASH);
          doc.push_back(CH_U);
          for (j = 0; j < 4; j++) begin
            h = $urandom_range(21);
            b = 8'((h < 10) ? "0" + h : (h < 16) ? "a" + h - 10 : "A" + h - 16);
            doc.push_back(b);
          end
        end
        default: begin
          b = 8'($urandom_range(255));
          if (b == CH_QUOTE || b == CH_BSLASH) b = "x";
          doc.push_back(b);
        end
      endcase
    end
    doc.push_back(CH_QUOTE);
  endfunction

  // well-formed object with random keys and values
  function automatic void build_object(input int members);
    logic [7:0] b;
    int m;
    int k;
    int n;
    put_blanks();
    doc.push_back(CH_LBRACE);
    for (m = 0; m < members; m++) begin
      if (m != 0) begin
        put_blanks();
        doc.push_back(CH_COMMA);
      end
      put_blanks();
      doc.push_back(CH_QUOTE);
      n = $urandom_range(5);
      for (k = 0; k < n; k++) begin
        b = 8'("a" + $urandom_range(25));
        doc.push_back(b);
      end
      doc.push_back(CH_QUOTE);
      put_blanks();
      doc.push_back(CH_COLON);
      put_blanks();
      if ($urandom_range(1)) begin
        put_string($urandom_range(6));
      end else begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) begin
          b = 8'("0" + $urandom_range(9));
          doc.push_back(b);
        end
      end
    end
    put_blanks();
    doc.push_back(CH_RBRACE);
    put_blanks();
  endfunction

  // break a well-formed object in one place
  function automatic void spoil_doc();
    logic [7:0] b;
    int at;
    at = $urandom_range(doc.size() - 1);
    b = 8'($urandom_range(255));
    case ($urandom_range(4))
      0: doc[at] = b;
      1: while (doc.size() > at + 1) void'(doc.pop_back());
      2: doc.insert(at, b);
      3: begin
        b = 8'($urandom_range(33, 126));
        doc.push_back(b);
      end
      default: begin
        doc.insert(at, b);
        doc.insert(at, CH_BSLASH);
      end
    endcase
  endfunction

  // send the built document, last mark on its final byte
  task automatic send_doc();
    logic took;
    int k;
    for (k = 0; k < doc.size(); k++) begin
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= doc[k];
      in_tlast <= (k == doc.size() - 1);
      do begin
        @(negedge clk);
        took = in_tready;
        @(posedge clk);
      end while (!took);
      words_sent++;
    end
    doc.delete();
  endtask

  // hold off the sender until every predicted word has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] b;
    int start_count;
    int pick;
    int n;
    int k;
    logic long_done;
    logic paused;
    long_done = 1'b0;
    paused = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty object
    put_text("{}");
    send_doc();
    // integer ended by a comma, unicode escape, extreme bytes, short escape, trailing blank
    put_text("{\"y\":7,\"z\":\"\\u0fAF");
    doc.push_back(8'hFF);
    doc.push_back(8'h00);
    put_text("\\n\"}\n");
    send_doc();
    // bad escape ends the document
    put_text("{\"a\":\"\\q");
    send_doc();
    drain_results();

    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      calm <= (words_sent - start_count >= 300) && (words_sent - start_count < 450);
      if (!paused && words_sent - start_count >= 600) begin
        paused = 1'b1;
        drain_results();
      end
      if (!long_done && words_sent - start_count >= 500) begin
        // one value long enough to saturate the position counter
        long_done = 1'b1;
        put_text("{\"k\":\"");
        for (k = 0; k < LONG_VALUE; k++) begin
          b = 8'("a" + $urandom_range(25));
          doc.push_back(b);
        end
        put_text("\"}");
        start_count += doc.size();
        send_doc();
      end
      pick = $urandom_range(99);
      if (pick < 90) begin
        n = ($urandom_range(99) < 10) ? $urandom_range(14, 17) : $urandom_range(1, 4);
        build_object(n);
        if (pick >= 70) spoil_doc();
      end else begin
        // noise
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          b = (k == 0 && $urandom_range(1)) ? CH_LBRACE : 8'($urandom_range(255));
          doc.push_back(b);
        end
      end
      send_doc();
    end

    calm <= 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
